FILE: rtl/core/binary_min_heap_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit_macros
// Assertion helpers used by the heap queue engine.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

FILE: rtl/core/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants, codes and types of the binary min-heap queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_BITS_DEF  = 8;
  localparam int PRIO_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int FRONT_DEPTH  = 2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_ROOT,
    ST_DN_LAST,
    ST_DN_ENT,
    ST_DN_RL,
    ST_DN_RR,
    ST_DN_CMP,
    ST_FIN
  } eng_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bmhq_front.sv
// ----------------------------------------------------------------------------
// bmhq_front
// Input side: takes operations and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_front #(
  parameter int ID_BITS = bmhq_pkg::ID_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic                        in_kind,
  input  wire logic [ID_BITS-1:0]          in_entry_id,
  input  wire logic [bmhq_pkg::PRIO_W-1:0] in_entry_priority,
  output logic                             cmd_valid,
  input  wire logic                        cmd_take,
  output logic                             cmd_kind,
  output logic [ID_BITS-1:0]               cmd_id,
  output logic [bmhq_pkg::PRIO_W-1:0]      cmd_prio
);

  import bmhq_pkg::*;

  localparam int W    = 1 + ID_BITS + PRIO_W;
  localparam int PTRW = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
  localparam int CNTW = $clog2(FRONT_DEPTH + 1);

  logic [W-1:0]    slot_r [FRONT_DEPTH];
  logic [PTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push_ok;
  logic            take_ok;
  logic [W-1:0]    head;

  assign in_full   = (cnt_r == CNTW'(FRONT_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign push_ok   = in_push && !in_full;
  assign take_ok   = cmd_take && cmd_valid;

  assign head     = slot_r[rd_ptr_r];
  assign cmd_kind = head[W-1];
  assign cmd_id   = head[W-2:PRIO_W];
  assign cmd_prio = head[PRIO_W-1:0];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(FRONT_DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (take_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(FRONT_DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (push_ok && !take_ok) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (take_ok && !push_ok) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= {in_kind, in_entry_id, in_entry_priority};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bmhq_engine.sv
// ----------------------------------------------------------------------------
// bmhq_engine
// Back side: runs one push (sift-up) or pop (sift-down) at a time on the
// heap RAM and produces one result per operation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_min_heap_queue_unit_macros.svh"

module bmhq_engine #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = bmhq_pkg::ID_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  output logic                               cmd_take,
  input  wire logic                          cmd_kind,
  input  wire logic [ID_BITS-1:0]            cmd_id,
  input  wire logic [bmhq_pkg::PRIO_W-1:0]   cmd_prio,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic [ID_BITS-1:0]                 res_id,
  output logic [bmhq_pkg::STATUS_W-1:0]      res_status,
  output logic [$clog2(CAPACITY+1)-1:0]      res_fill
);

  import bmhq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 1;
  localparam int EW = ID_BITS + PRIO_W;

  eng_state_t               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [ID_BITS-1:0]       id_r, id_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;
  logic [ID_BITS-1:0]       child_id_r, child_id_nxt;
  logic signed [PRIO_W-1:0] child_prio_r, child_prio_nxt;
  logic                     has_right_r, has_right_nxt;
  logic [ID_BITS-1:0]       res_id_r, res_id_nxt;
  logic [STATUS_W-1:0]      res_status_r, res_status_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [EW-1:0]            ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [EW-1:0]            ram_rdata;

  logic [ID_BITS-1:0]       rd_id;
  logic signed [PRIO_W-1:0] rd_prio;
  logic [LW-1:0]            count_ext;
  logic [LW-1:0]            left_idx;
  logic [LW:0]              right_idx;
  logic [AW-1:0]            parent_idx;
  logic                     take_l;
  logic signed [PRIO_W-1:0] best_prio;
  logic                     take_r;

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_id     = ram_rdata[EW-1:PRIO_W];
  assign rd_prio   = $signed(ram_rdata[PRIO_W-1:0]);
  assign count_ext = LW'(count_r);
  assign left_idx  = {pos_r, 1'b1};
  assign right_idx = {1'b0, left_idx} + (LW+1)'(1);
  assign parent_idx = (pos_r - AW'(1)) >> 1;

  // Sift-down choice: a child wins only when strictly smaller, left on a tie.
  assign take_l    = (child_prio_r < prio_r);
  assign best_prio = take_l ? child_prio_r : prio_r;
  assign take_r    = has_right_r && (rd_prio < best_prio);

  assign res_id     = res_id_r;
  assign res_status = res_status_r;
  assign res_fill   = count_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    id_nxt         = id_r;
    prio_nxt       = prio_r;
    child_id_nxt   = child_id_r;
    child_prio_nxt = child_prio_r;
    has_right_nxt  = has_right_r;
    res_id_nxt     = res_id_r;
    res_status_nxt = res_status_r;
    cmd_take       = 1'b0;
    res_valid      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = {id_r, prio_r};
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take       = 1'b1;
          id_nxt         = cmd_id;
          prio_nxt       = $signed(cmd_prio);
          res_id_nxt     = '0;
          res_status_nxt = STAT_OK;
          if (cmd_kind == KIND_PUSH) begin
            if (count_r == CW'(CAPACITY)) begin
              res_status_nxt = STAT_FULL;
              state_nxt      = ST_FIN;
            end else begin
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = ST_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = STAT_EMPTY;
              state_nxt      = ST_FIN;
            end else begin
              state_nxt = ST_DN_ROOT;
            end
          end
        end
      end

      ST_UP_RD: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent_idx;
          state_nxt = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (rd_prio > prio_r) begin
          // Parent moves down into the hole; the new entry stays in registers.
          ram_wdata = ram_rdata;
          pos_nxt   = parent_idx;
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_DN_ROOT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        count_nxt = count_r - CW'(1);
        state_nxt = ST_DN_LAST;
      end

      ST_DN_LAST: begin
        res_id_nxt = rd_id;
        if (count_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = count_r[AW-1:0];
          state_nxt = ST_DN_ENT;
        end
      end

      ST_DN_ENT: begin
        id_nxt    = rd_id;
        prio_nxt  = rd_prio;
        pos_nxt   = '0;
        state_nxt = ST_DN_RL;
      end

      ST_DN_RL: begin
        if (left_idx >= count_ext) begin
          ram_we    = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = left_idx[AW-1:0];
          state_nxt = ST_DN_RR;
        end
      end

      ST_DN_RR: begin
        child_id_nxt   = rd_id;
        child_prio_nxt = rd_prio;
        if (right_idx < {1'b0, count_ext}) begin
          ram_re        = 1'b1;
          ram_raddr     = right_idx[AW-1:0];
          has_right_nxt = 1'b1;
        end else begin
          has_right_nxt = 1'b0;
        end
        state_nxt = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        ram_we = 1'b1;
        if (take_r) begin
          ram_wdata = ram_rdata;
          pos_nxt   = right_idx[AW-1:0];
          state_nxt = ST_DN_RL;
        end else if (take_l) begin
          ram_wdata = {child_id_r, child_prio_r};
          pos_nxt   = left_idx[AW-1:0];
          state_nxt = ST_DN_RL;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    id_r         <= id_nxt;
    prio_r       <= prio_nxt;
    child_id_r   <= child_id_nxt;
    child_prio_r <= child_prio_nxt;
    has_right_r  <= has_right_nxt;
    res_id_r     <= res_id_nxt;
    res_status_r <= res_status_nxt;
  end

  `BMHQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `BMHQ_ASSERT_IMP(a_write_in_heap, clk, rst_n, ram_we, LW'(ram_waddr) < count_ext)
  `BMHQ_ASSERT_IMP(a_full_status, clk, rst_n,
                   res_valid && res_status_r == STAT_FULL, count_r == CW'(CAPACITY))
  `BMHQ_ASSERT_IMP(a_empty_status, clk, rst_n,
                   res_valid && res_status_r == STAT_EMPTY, count_r == '0 && res_id_r == '0)
  `BMHQ_ASSERT_NXT(a_pop_shrinks, clk, rst_n, state_r == ST_DN_ROOT,
                   count_r == $past(count_r) - CW'(1))

endmodule

`default_nettype wire

FILE: rtl/core/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue of (id, signed priority) entries, up to
// CAPACITY held. Each input item is a push or a pop and yields one result item
// with the popped id, a status (ok, pop on empty, push on full dropped) and the
// fill count after the operation. Items enter a two-deep input queue and are
// executed one at a time on a single heap RAM with registered read; a result
// waits in an output register while the next item is already being worked on.
// Each heap level costs one RAM read and a compare on a push and two reads and
// a compare on a pop; pushes on a full heap and pops on an empty one go
// straight to the result without touching the RAM.
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit
// Top level: input queue, heap engine and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue_unit #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = bmhq_pkg::ID_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_kind,
  input  wire logic [ID_BITS-1:0]            in_entry_id,
  input  wire logic [bmhq_pkg::PRIO_W-1:0]   in_entry_priority,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [ID_BITS-1:0]                 out_popped_id,
  output logic [bmhq_pkg::STATUS_W-1:0]      out_status,
  output logic [$clog2(CAPACITY+1)-1:0]      out_fill_count
);

  import bmhq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic                cmd_valid;
  logic                cmd_take;
  logic                cmd_kind;
  logic [ID_BITS-1:0]  cmd_id;
  logic [PRIO_W-1:0]   cmd_prio;
  logic                res_valid;
  logic                res_ready;
  logic [ID_BITS-1:0]  res_id;
  logic [STATUS_W-1:0] res_status;
  logic [CW-1:0]       res_fill;

  logic                out_valid_r, out_valid_nxt;
  logic [ID_BITS-1:0]  out_id_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CW-1:0]       out_fill_r;
  logic                out_take;

  bmhq_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_entry_id       (in_entry_id),
    .in_entry_priority (in_entry_priority),
    .cmd_valid         (cmd_valid),
    .cmd_take          (cmd_take),
    .cmd_kind          (cmd_kind),
    .cmd_id            (cmd_id),
    .cmd_prio          (cmd_prio)
  );

  bmhq_engine #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take),
    .cmd_kind   (cmd_kind),
    .cmd_id     (cmd_id),
    .cmd_prio   (cmd_prio),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_id     (res_id),
    .res_status (res_status),
    .res_fill   (res_fill)
  );

  assign out_take  = out_pop && out_valid_r;
  assign res_ready = !out_valid_r || out_take;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_id_r     <= res_id;
      out_status_r <= res_status;
      out_fill_r   <= res_fill;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_popped_id  = out_id_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary min-heap queue unit. An opening table
// covers the priority extremes, ties and the empty-heap pop. Random bursts
// then fill and drain the heap under several idling mixes and a long output
// stall. Every result item is compared with the table's result where one is
// given, else with a heap predictor kept here.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int FILL_W   = $clog2(CAPACITY_DEF + 1);
  localparam int PHASES   = 4;
  localparam int PHASE_OPS = 480;

  typedef struct packed {
    logic [ID_BITS_DEF-1:0] id;
    status_t                status;
    logic [FILL_W-1:0]      fill;
  } heap_result_t;

  // One operation; the result is given in the table only where it is obvious.
  typedef struct packed {
    logic                   typed;
    logic                   kind;
    logic [ID_BITS_DEF-1:0] id;
    logic [PRIO_W-1:0]      prio;
    heap_result_t           want;
  } heap_op_t;

  localparam heap_result_t UNTYPED = '{8'h00, STAT_OK, 7'd0};
  localparam logic [PRIO_W-1:0] PRIO_MIN = 32'h8000_0000;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 32'h7FFF_FFFF;

  localparam heap_op_t OPENING_OPS [24] = '{
    '{1'b1, KIND_POP,  8'h00, 32'h0,        '{8'h00, STAT_EMPTY, 7'd0}},
    '{1'b1, KIND_PUSH, 8'hFF, PRIO_MAX,     '{8'h00, STAT_OK, 7'd1}},
    '{1'b1, KIND_PUSH, 8'h00, PRIO_MIN,     '{8'h00, STAT_OK, 7'd2}},
    '{1'b0, KIND_PUSH, 8'h01, 32'h0,        UNTYPED},
    '{1'b0, KIND_PUSH, 8'h02, 32'h0,        UNTYPED},
    '{1'b0, KIND_PUSH, 8'h03, 32'hFFFF_FFFF, UNTYPED},
    '{1'b0, KIND_PUSH, 8'h04, 32'h1,        UNTYPED},
    '{1'b0, KIND_PUSH, 8'h05, 32'h0,        UNTYPED},
    '{1'b0, KIND_PUSH, 8'h06, 32'h0,        UNTYPED},
    '{1'b1, KIND_POP,  8'hFF, 32'h0,        '{8'h00, STAT_OK, 7'd7}},
    '{1'b0, KIND_POP,  8'h00, 32'h0,        UNTYPED},
    '{1'b0, KIND_POP,  8'h00, PRIO_MAX,     UNTYPED},
    '{1'b0, KIND_POP,  8'h00, 32'h0,        UNTYPED},
    '{1'b0, KIND_POP,  8'h00, 32'h0,        UNTYPED},
    '{1'b0, KIND_POP,  8'h00, 32'h0,        UNTYPED},
    '{1'b0, KIND_POP,  8'h00, 32'h0,        UNTYPED},
    '{1'b1, KIND_POP,  8'h00, 32'h0,        '{8'hFF, STAT_OK, 7'd0}},
    '{1'b1, KIND_POP,  8'h00, 32'h0,        '{8'h00, STAT_EMPTY, 7'd0}},
    '{1'b0, KIND_PUSH, 8'h5A, PRIO_MIN,     UNTYPED},
    '{1'b0, KIND_PUSH, 8'hA5, PRIO_MIN,     UNTYPED},
    '{1'b0, KIND_POP,  8'h00, 32'h0,        UNTYPED},
    '{1'b0, KIND_POP,  8'h00, 32'h0,        UNTYPED},
    '{1'b0, KIND_PUSH, 8'h7E, PRIO_MAX,     UNTYPED},
    '{1'b1, KIND_POP,  8'h00, 32'h0,        '{8'h7E, STAT_OK, 7'd0}}
  };

  localparam int SEND_IDLE_PCT  [PHASES] = '{0, 64, 0, 24};
  localparam int RECV_STALL_PCT [PHASES] = '{0, 0, 64, 24};

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic                       in_kind = KIND_PUSH;
  logic [ID_BITS_DEF-1:0]     in_entry_id = '0;
  logic [PRIO_W-1:0]          in_entry_priority = '0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic [ID_BITS_DEF-1:0]     out_popped_id;
  logic [STATUS_W-1:0]        out_status;
  logic [FILL_W-1:0]          out_fill_count;

  // Predictor state: the heap as an array of ids and signed priorities.
  logic [ID_BITS_DEF-1:0]     slot_id [CAPACITY_DEF];
  int                         slot_prio [CAPACITY_DEF];
  int                         held = 0;

  heap_result_t               awaited_results [$];
  int                         mismatches = 0;
  int                         send_idle_pct = 0;
  int                         recv_stall_pct = 0;
  int                         hold_off_left = 0;

  binary_min_heap_queue_unit #(
    .CAPACITY (CAPACITY_DEF),
    .ID_BITS  (ID_BITS_DEF)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_kind           (in_kind),
    .in_entry_id       (in_entry_id),
    .in_entry_priority (in_entry_priority),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_popped_id     (out_popped_id),
    .out_status        (out_status),
    .out_fill_count    (out_fill_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void swap_slots(int a, int b);
    logic [ID_BITS_DEF-1:0] t_id;
    int t_prio;
    t_id = slot_id[a];
    t_prio = slot_prio[a];
    slot_id[a] = slot_id[b];
    slot_prio[a] = slot_prio[b];
    slot_id[b] = t_id;
    slot_prio[b] = t_prio;
  endfunction

  // Applies one operation to the heap copy and returns the result it yields.
  function automatic heap_result_t predict_heap_op(heap_op_t op);
    heap_result_t res;
    int pos;
    int parent;
    int best;
    int left;
    int right;
    res = UNTYPED;
    if (op.kind == KIND_PUSH) begin
      if (held >= CAPACITY_DEF) begin
        res.status = STAT_FULL;
      end else begin
        pos = held;
        slot_id[pos] = op.id;
        slot_prio[pos] = int'(signed'(op.prio));
        held++;
        // A push stops at a parent of equal priority.
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (slot_prio[parent] <= slot_prio[pos]) break;
          swap_slots(pos, parent);
          pos = parent;
        end
      end
    end else if (held == 0) begin
      res.status = STAT_EMPTY;
    end else begin
      res.id = slot_id[0];
      held--;
      if (held > 0) begin
        slot_id[0] = slot_id[held];
        slot_prio[0] = slot_prio[held];
        pos = 0;
        // Strictly smaller children only; the left one wins a tie.
        forever begin
          best = pos;
          left = 2 * pos + 1;
          right = 2 * pos + 2;
          if (left < held && slot_prio[left] < slot_prio[best]) best = left;
          if (right < held && slot_prio[right] < slot_prio[best]) best = right;
          if (best == pos) break;
          swap_slots(pos, best);
          pos = best;
        end
      end
    end
    res.fill = FILL_W'(held);
    return res;
  endfunction

  // Small priorities half the time so that ties are frequent, else random or extremes.
  function automatic logic [PRIO_W-1:0] pick_priority();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return PRIO_MIN;
          1: return PRIO_MAX;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3, 4: return $urandom;
      default: return 32'($urandom_range(6)) - 32'd3;
    endcase
  endfunction

  function automatic heap_op_t random_op(int push_pct);
    heap_op_t op;
    op.typed = 1'b0;
    op.kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
    op.id = ID_BITS_DEF'($urandom_range(255));
    op.prio = pick_priority();
    op.want = UNTYPED;
    return op;
  endfunction

  // Offers one item and waits until it is taken.
  task automatic send_item(input heap_op_t op);
    heap_result_t predicted;
    in_push <= 1'b1;
    in_kind <= op.kind;
    in_entry_id <= op.id;
    in_entry_priority <= op.prio;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    predicted = predict_heap_op(op);
    awaited_results.push_back(op.typed ? op.want : predicted);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_all_results();
    in_push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input heap_result_t exp);
    if (out_popped_id !== exp.id) begin
      $display("%0t: popped_id mismatch: expected %0d, got %0d", $time, exp.id, out_popped_id);
      mismatches++;
    end
    if (out_status !== exp.status) begin
      $display("%0t: status mismatch: expected %0d, got %0d", $time, exp.status, out_status);
      mismatches++;
    end
    if (out_fill_count !== exp.fill) begin
      $display("%0t: fill_count mismatch: expected %0d, got %0d", $time, exp.fill,
               out_fill_count);
      mismatches++;
    end
  endtask

  // Result side: checks at each edge, then picks the pop for the next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && out_empty === 1'b0) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result item: id %0d status %0d fill %0d", $time,
                   out_popped_id, out_status, out_fill_count);
          mismatches++;
        end else begin
          check_result(awaited_results.pop_front());
        end
      end
      if (!rst_n) begin
        out_pop <= 1'b0;
      end else if (hold_off_left > 0) begin
        hold_off_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int burst;
    int issued;
    int push_pct;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING_OPS[r]) send_item(OPENING_OPS[r]);
    wait_all_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = SEND_IDLE_PCT[ph];
      recv_stall_pct = RECV_STALL_PCT[ph];
      if (ph == 0) begin
        // Long output stall with the input kept busy, so the unit backs up.
        hold_off_left = 300;
        repeat (40) send_item(random_op(80));
        wait_all_results();
      end
      issued = 0;
      while (issued < PHASE_OPS) begin
        // Bursts lean toward filling, draining or neither, to reach both ends.
        burst = $urandom_range(20, 120);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
        repeat (burst) begin
          send_item(random_op(push_pct));
          sender_gap();
        end
        issued += burst;
      end
      wait_all_results();
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_ram.sv
rtl/core/bmhq_front.sv
rtl/core/bmhq_engine.sv
rtl/core/binary_min_heap_queue_unit.sv
bench/tb_top.sv
